// ----- hdl/planar_screen_resolution_guesser_macros.svh -----
// assertion helpers for the resolution guesser checker
`ifndef PLANAR_SCREEN_RESOLUTION_GUESSER_MACROS_SVH
`define PLANAR_SCREEN_RESOLUTION_GUESSER_MACROS_SVH

// checked only outside reset
`define PSRG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("psrg check failed");

// checked during reset as well
`define PSRG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("psrg check failed during reset");

`endif

// ----- hdl/psrg_pkg.sv -----
`timescale 1ns / 1ps

package psrg_pkg;

  localparam int unsigned MonoBytes   = 2;
  localparam int unsigned MediumBytes = 4;
  localparam int unsigned LowBytes    = 8;

  typedef enum logic [1:0] {
    RES_LOW    = 2'd0,
    RES_MEDIUM = 2'd1,
    RES_MONO   = 2'd2
  } res_code_e;

  typedef struct packed {
    logic [15:0] screen_word;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  resolution_code;
    logic [15:0] mono_repeats;
    logic [15:0] medium_repeats;
    logic [15:0] low_repeats;
  } out_word_t;

  // 2 bits per pixel, byte 0 first
  function automatic logic [MediumBytes-1:0][7:0] medium_bytes(logic [15:0] w0,
                                                               logic [15:0] w1);
    logic [MediumBytes-1:0][7:0] b;
    for (int j = 0; j < MediumBytes; j++) begin
      for (int k = 0; k < 4; k++) begin
        b[j][7-2*k] = w0[15-4*j-k];
        b[j][6-2*k] = w1[15-4*j-k];
      end
    end
    return b;
  endfunction

  // 4 bits per pixel, byte 0 first
  function automatic logic [LowBytes-1:0][7:0] low_bytes(logic [15:0] w0, logic [15:0] w1,
                                                         logic [15:0] w2, logic [15:0] w3);
    logic [LowBytes-1:0][7:0] b;
    for (int j = 0; j < LowBytes; j++) begin
      for (int k = 0; k < 2; k++) begin
        b[j][7-4*k] = w0[15-2*j-k];
        b[j][6-4*k] = w1[15-2*j-k];
        b[j][5-4*k] = w2[15-2*j-k];
        b[j][4-4*k] = w3[15-2*j-k];
      end
    end
    return b;
  endfunction

endpackage

// ----- hdl/planar_screen_resolution_guesser.sv -----
`timescale 1ns / 1ps

// Guesses the resolution of a raw interleaved-bitplane screen dump streamed in as
// big-endian 16-bit words, one word accepted per clock cycle with no gaps needed.
// Three lanes (mono bytes, medium word pairs, low groups of four words) count
// repeated bytes in parallel, each lane updating in the cycle its word is taken.
// The word flagged last_word closes the dump: its counts are captured, all lane
// state returns to zero so the following word starts a new dump, and one result
// word goes via the snapshot to the merge register. Input stalls only when
// a captured result and the output register are both still waiting to be taken.

module planar_screen_resolution_guesser #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psrg_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psrg_pkg::out_word_t out_word_o
);

  import psrg_pkg::*;

  logic                         accept;
  logic                         clr;
  logic                         medium_en;
  logic                         low_en;
  logic [1:0]                   pos_q;
  logic [15:0]                  group0_q, group1_q, group2_q;
  logic [15:0]                  w;
  logic [15:0]                  pair_w0;
  logic [MonoBytes-1:0][7:0]    mono_b;
  logic [MediumBytes-1:0][7:0]  medium_b;
  logic [LowBytes-1:0][7:0]     low_b;
  logic [COUNT_BITS-1:0]        mono_next, medium_next, low_next;
  logic                         snap_valid_q;
  logic [COUNT_BITS-1:0]        snap_mono_q, snap_medium_q, snap_low_q;
  logic                         advance;

  assign w         = in_word_i.screen_word;
  assign accept    = in_valid_i && in_ready_o;
  assign clr       = accept && in_word_i.last_word;
  assign medium_en = accept && pos_q[0];
  assign low_en    = accept && (pos_q == 2'd3);
  assign in_ready_o = !snap_valid_q || advance;

  assign pair_w0  = pos_q[1] ? group2_q : group0_q;
  assign mono_b   = {w[7:0], w[15:8]};
  assign medium_b = medium_bytes(pair_w0, w);
  assign low_b    = low_bytes(group0_q, group1_q, group2_q, w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (clr) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      unique case (pos_q)
        2'd0: group0_q <= w;
        2'd1: group1_q <= w;
        2'd2: group2_q <= w;
        2'd3: ;
        default: ;
      endcase
    end
  end

  psrg_lane #(.NUM_BYTES(MonoBytes), .COUNT_BITS(COUNT_BITS)) u_mono (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .clr_i        (clr),
    .bytes_i      (mono_b),
    .count_next_o (mono_next)
  );

  psrg_lane #(.NUM_BYTES(MediumBytes), .COUNT_BITS(COUNT_BITS)) u_medium (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (medium_en),
    .clr_i        (clr),
    .bytes_i      (medium_b),
    .count_next_o (medium_next)
  );

  psrg_lane #(.NUM_BYTES(LowBytes), .COUNT_BITS(COUNT_BITS)) u_low (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (low_en),
    .clr_i        (clr),
    .bytes_i      (low_b),
    .count_next_o (low_next)
  );

  // final counts of a finished dump
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (clr) begin
      snap_valid_q <= 1'b1;
    end else if (advance) begin
      snap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr) begin
      snap_mono_q   <= mono_next;
      snap_medium_q <= medium_next;
      snap_low_q    <= low_next;
    end
  end

  psrg_merge #(.COUNT_BITS(COUNT_BITS)) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .snap_valid_i   (snap_valid_q),
    .mono_count_i   (snap_mono_q),
    .medium_count_i (snap_medium_q),
    .low_count_i    (snap_low_q),
    .advance_o      (advance),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_word_o     (out_word_o)
  );

endmodule

// ----- hdl/psrg_lane.sv -----
`timescale 1ns / 1ps

module psrg_lane #(
  parameter int unsigned NUM_BYTES  = 2,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            clr_i,
  input  logic [NUM_BYTES-1:0][7:0]       bytes_i,
  output logic [COUNT_BITS-1:0]           count_next_o
);

  localparam int unsigned MatchBits = $clog2(NUM_BYTES + 1);

  logic [7:0]            prev_q;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [NUM_BYTES-1:0]  hit;
  logic [MatchBits-1:0]  hit_cnt;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sat;

  // each byte is compared with the byte before it in the stream
  for (genvar i = 0; i < NUM_BYTES; i++) begin : g_hit
    if (i == 0) begin : g_first
      assign hit[i] = (bytes_i[i] == prev_q);
    end else begin : g_rest
      assign hit[i] = (bytes_i[i] == bytes_i[i-1]);
    end
  end

  assign hit_cnt = MatchBits'($countones(hit));
  assign sum     = {1'b0, count_q} + (COUNT_BITS + 1)'(hit_cnt);
  assign sat     = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  assign count_d = en_i ? sat : count_q;
  assign count_next_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      prev_q  <= '0;
    end else if (clr_i) begin
      count_q <= '0;
      prev_q  <= '0;
    end else if (en_i) begin
      count_q <= count_d;
      prev_q  <= bytes_i[NUM_BYTES-1];
    end
  end

endmodule

// ----- hdl/psrg_merge.sv -----
`timescale 1ns / 1ps

module psrg_merge #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  snap_valid_i,
  input  logic [COUNT_BITS-1:0] mono_count_i,
  input  logic [COUNT_BITS-1:0] medium_count_i,
  input  logic [COUNT_BITS-1:0] low_count_i,
  output logic                  advance_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output psrg_pkg::out_word_t   out_word_o
);

  import psrg_pkg::*;

  logic [2:0][COUNT_BITS-1:0] cnt;
  logic [2:0][15:0]           rep;
  res_code_e                  code;
  logic                       out_valid_q;
  out_word_t                  out_word_q;

  assign cnt = {mono_count_i, medium_count_i, low_count_i};

  for (genvar i = 0; i < 3; i++) begin : g_rep
    if (COUNT_BITS > 16) begin : g_clamp
      assign rep[i] = (|cnt[i][COUNT_BITS-1:16]) ? 16'hFFFF : cnt[i][15:0];
    end else begin : g_ext
      assign rep[i] = 16'(cnt[i]);
    end
  end

  always_comb begin
    priority if (mono_count_i >= low_count_i && mono_count_i >= medium_count_i) begin
      code = RES_MONO;
    end else if (medium_count_i > low_count_i) begin
      code = RES_MEDIUM;
    end else begin
      code = RES_LOW;
    end
  end

  assign advance_o = snap_valid_i && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      out_word_q.resolution_code <= code;
      out_word_q.mono_repeats    <= rep[2];
      out_word_q.medium_repeats  <= rep[1];
      out_word_q.low_repeats     <= rep[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- hdl/psrg_checker.sv -----
`timescale 1ns / 1ps
`include "planar_screen_resolution_guesser_macros.svh"

module psrg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input psrg_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input psrg_pkg::out_word_t out_word_o
);

  import psrg_pkg::*;

  `PSRG_ASSERT_ALWAYS(a_no_word_in_reset, !rst_ni |-> !out_valid_o)
  `PSRG_ASSERT(a_held_until_taken, out_valid_o && !out_ready_i |=> out_valid_o)
  `PSRG_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o)
  `PSRG_ASSERT(a_mono_leads,
    out_valid_o && out_word_o.resolution_code == RES_MONO |->
      out_word_o.mono_repeats >= out_word_o.medium_repeats &&
      out_word_o.mono_repeats >= out_word_o.low_repeats)
  `PSRG_ASSERT(a_low_not_beaten,
    out_valid_o && out_word_o.resolution_code == RES_LOW |->
      out_word_o.low_repeats >= out_word_o.medium_repeats)

endmodule

bind planar_screen_resolution_guesser psrg_checker u_psrg_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import psrg_pkg::*;

  localparam int unsigned CountBits   = 16;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomWords = 1240;
  localparam int unsigned FlatWords   = 150;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  planar_screen_resolution_guesser #(
    .COUNT_BITS(CountBits)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  in_word_t    screen_words[$];
  out_word_t   expected_guesses[$];
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_hold_left = 0;
  logic        sink_hold_request = 1'b0;
  logic        sink_hold_done = 1'b0;
  logic        word_taken = 1'b0;
  logic        quiet;

  assign quiet = cycle_count >= 800 && cycle_count < 1200;

  // predictor state
  logic [7:0]           mono_last;
  logic [7:0]           medium_last;
  logic [7:0]           low_last;
  logic [CountBits-1:0] mono_hits;
  logic [CountBits-1:0] medium_hits;
  logic [CountBits-1:0] low_hits;
  logic [15:0]          group_buf[3];
  logic [1:0]           group_slot;

  task automatic clear_guesser();
    mono_last   = '0;
    medium_last = '0;
    low_last    = '0;
    mono_hits   = '0;
    medium_hits = '0;
    low_hits    = '0;
    group_buf[0] = '0;
    group_buf[1] = '0;
    group_buf[2] = '0;
    group_slot  = '0;
  endtask

  task automatic count_byte(input logic [7:0] b, inout logic [7:0] prev,
                            inout logic [CountBits-1:0] hits);
    if (b == prev) begin
      if (hits != {CountBits{1'b1}}) hits = hits + 1'b1;
    end else begin
      prev = b;
    end
  endtask

  task automatic fold_pair(input logic [15:0] a, input logic [15:0] b);
    logic [7:0]  chunk;
    int unsigned bitpos;
    for (int j = 0; j < 4; j++) begin
      chunk = '0;
      for (int k = 0; k < 4; k++) begin
        bitpos = 15 - 4 * j - k;
        chunk = {chunk[5:0], a[bitpos], b[bitpos]};
      end
      count_byte(chunk, medium_last, medium_hits);
    end
  endtask

  task automatic fold_group(input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] c, input logic [15:0] d);
    logic [7:0]  chunk;
    int unsigned bitpos;
    for (int j = 0; j < 8; j++) begin
      chunk = '0;
      for (int k = 0; k < 2; k++) begin
        bitpos = 15 - 2 * j - k;
        chunk = {chunk[3:0], a[bitpos], b[bitpos], c[bitpos], d[bitpos]};
      end
      count_byte(chunk, low_last, low_hits);
    end
  endtask

  function automatic logic [15:0] clip16(input logic [CountBits-1:0] v);
    return (v > 'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic guess_word(input in_word_t w);
    out_word_t  guess;
    logic [1:0] slot;
    slot = group_slot;
    count_byte(w.screen_word[15:8], mono_last, mono_hits);
    count_byte(w.screen_word[7:0], mono_last, mono_hits);
    if (slot == 2'd1) fold_pair(group_buf[0], w.screen_word);
    else if (slot == 2'd3) fold_pair(group_buf[2], w.screen_word);
    if (slot == 2'd3) fold_group(group_buf[0], group_buf[1], group_buf[2], w.screen_word);
    else group_buf[slot] = w.screen_word;
    group_slot = slot + 2'd1;
    if (w.last_word) begin
      if (mono_hits >= low_hits && mono_hits >= medium_hits) guess.resolution_code = RES_MONO;
      else if (medium_hits > low_hits) guess.resolution_code = RES_MEDIUM;
      else guess.resolution_code = RES_LOW;
      guess.mono_repeats   = clip16(mono_hits);
      guess.medium_repeats = clip16(medium_hits);
      guess.low_repeats    = clip16(low_hits);
      expected_guesses.push_back(guess);
      clear_guesser();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < 100)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // monitor
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      word_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        guess_word(in_word_i);
        words_taken <= words_taken + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_guesses.size() == 0) begin
          report_mismatch("unexpected result word", out_word_o.mono_repeats, '0);
        end else begin
          want = expected_guesses.pop_front();
          if (out_word_o.resolution_code !== want.resolution_code)
            report_mismatch("resolution_code", 16'(out_word_o.resolution_code),
                            16'(want.resolution_code));
          if (out_word_o.mono_repeats !== want.mono_repeats)
            report_mismatch("mono_repeats", out_word_o.mono_repeats, want.mono_repeats);
          if (out_word_o.medium_repeats !== want.medium_repeats)
            report_mismatch("medium_repeats", out_word_o.medium_repeats,
                            want.medium_repeats);
          if (out_word_o.low_repeats !== want.low_repeats)
            report_mismatch("low_repeats", out_word_o.low_repeats, want.low_repeats);
        end
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (screen_words.size() != 0 && (quiet || $urandom_range(99) >= 14)) begin
        in_word_i  <= screen_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i)
    out_ready_i <= rst_ni && sink_hold_left == 0 && (quiet || $urandom_range(99) >= 14);

  always @(posedge clk_i) begin
    if (sink_hold_request && !sink_hold_done) begin
      sink_hold_left <= HoldCycles;
      sink_hold_done <= 1'b1;
    end else if (sink_hold_left != 0) begin
      sink_hold_left <= sink_hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("planar_screen_resolution_guesser test failed");
      $finish;
    end
  end

  task automatic queue_word(input logic [15:0] w, input logic last);
    in_word_t item;
    item.screen_word = w;
    item.last_word   = last;
    screen_words.push_back(item);
    words_queued++;
  endtask

  function automatic logic [15:0] styled_word(input int unsigned style);
    logic [15:0] r;
    r = 16'($urandom);
    case (style)
      1: return {r[7:0], r[7:0]};
      2: return {4{r[3:0]}};
      3: return {8{r[1:0]}};
      default: return r;
    endcase
  endfunction

  task automatic queue_random_dump();
    logic [15:0] pattern[4];
    int unsigned len;
    int unsigned period;
    int unsigned offset;
    int unsigned noise;
    int unsigned style;
    if ($urandom_range(99) < 8) len = $urandom_range(200, 60);
    else len = $urandom_range(24, 1);
    case ($urandom_range(2))
      0: period = 1;
      1: period = 2;
      default: period = 4;
    endcase
    offset = $urandom_range(3);
    noise  = $urandom_range(30);
    style  = $urandom_range(3);
    for (int i = 0; i < 4; i++)
      pattern[i] = styled_word(($urandom_range(3) == 0) ? $urandom_range(3) : style);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise) queue_word(16'($urandom), i == len - 1);
      else queue_word(pattern[(i + offset) % period], i == len - 1);
    end
  endtask

  task automatic wait_until_idle();
    while (words_taken != words_queued || expected_guesses.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned random_start;
    clear_guesser();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_word(16'h0000, 1'b1);
    queue_word(16'hFFFF, 1'b1);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'h0000, 1'b1);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'h0000, 1'b0);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'h0000, 1'b1);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'h0000, 1'b0);
    queue_word(16'h0000, 1'b1);
    queue_word(16'h0000, 1'b0);
    queue_word(16'h0000, 1'b1);
    queue_word(16'h8000, 1'b0);
    queue_word(16'h0001, 1'b0);
    queue_word(16'h7FFE, 1'b1);
    queue_word(16'h5555, 1'b0);
    queue_word(16'hAAAA, 1'b0);
    queue_word(16'h1111, 1'b0);
    queue_word(16'hEEEE, 1'b0);
    queue_word(16'h00FF, 1'b1);
    wait_until_idle();

    // long flat dump repeats nearly every byte in all three lanes
    for (int unsigned i = 0; i < FlatWords; i++) queue_word(16'h0000, i == FlatWords - 1);
    wait_until_idle();

    // results pile up while the sink holds off
    sink_hold_request = 1'b1;
    for (int i = 0; i < 40; i++) queue_word(16'($urandom), 1'b1);

    random_start = words_queued;
    while (words_queued - random_start < RandomWords) queue_random_dump();
    wait_until_idle();
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatch_count == 0 && expected_guesses.size() == 0) begin
      $display("planar_screen_resolution_guesser test passed");
    end else begin
      $display("planar_screen_resolution_guesser test failed");
    end
    $finish;
  end

endmodule
